[hw/rtl/dss_pkg.sv]
package dss_pkg;

  // Delimiter geometry
  localparam int MAX_DELIM  = 8;
  localparam int WIN_IDX_W  = (MAX_DELIM > 1) ? $clog2(MAX_DELIM) : 1;
  localparam int CNT_W      = $clog2(MAX_DELIM + 1);
  localparam int DELIM_W    = 8 * MAX_DELIM;
  localparam int LEN_W      = 4;

  // One input item can raise one result for its byte, a flush of the
  // remaining window and the closing field end.
  localparam int MAX_RES    = MAX_DELIM + 1;
  localparam int RES_CNT_W  = $clog2(MAX_RES + 1);

  // Result queue: a full burst plus one result still waiting downstream.
  localparam int QDEPTH     = MAX_RES + 1;
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  // Configuration register map
  localparam int CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_DELIM_BYTES  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELIM_LENGTH = 1'b1;
  localparam logic [DELIM_W-1:0]   DELIM_RESET      = DELIM_W'(44);
  localparam logic [LEN_W-1:0]     LEN_RESET        = LEN_W'(1);

  // One result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       field_end;
    logic       last;
  } res_t;

  // Burst of results raised by one accepted input item
  typedef struct packed {
    logic                      en;
    logic [RES_CNT_W-1:0]      cnt;
    res_t [MAX_RES-1:0]        items;
  } push_t;

endpackage

[hw/rtl/dss_chan_if.sv]
// Input channel: a string byte, an end marker or both per transaction.
interface dss_in_if import dss_pkg::*;;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  logic       has_data;
  logic       end_of_string;

  modport source (output valid, output data, output has_data, output end_of_string,
                  input ready);
  modport sink   (input valid, input data, input has_data, input end_of_string,
                  output ready);
endinterface

// Result channel: one field byte or field end per transaction.
interface dss_out_if import dss_pkg::*;;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       field_end;
  logic       last;

  modport source (output valid, output out_byte, output field_end, output last,
                  input ready);
  modport sink   (input valid, input out_byte, input field_end, input last,
                  output ready);
endinterface

[hw/rtl/delimiter_string_split.sv]
// Channel  Direction  Payload                          Transaction
// in_ch    sink       data, has_data, end_of_string    valid && ready
// out_ch   source     out_byte, field_end, last        valid && ready
// cfg_*    write      cfg_index, cfg_wdata             cfg_we
//
// One input item is taken per cycle while the queue has room; its results are
// queued in the next cycle. Results leave at one per cycle while out_ch is ready,
// from a ten-entry queue; an end-of-string flush can raise up to nine results.
// Input is taken while at most one result remains queued after this cycle.
// Synchronous active-low reset zeroes the window and queue counts, presets config.
module delimiter_string_split import dss_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  dss_in_if.sink               in_ch,
  dss_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DELIM_W-1:0]   cfg_wdata
);

  logic  acc;
  logic  can_take;
  push_t push;

  assign in_ch.ready = can_take;
  assign acc         = in_ch.valid && in_ch.ready;

  // Window, matching and burst assembly.
  dss_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .acc       (acc),
    .data      (in_ch.data),
    .has_data  (in_ch.has_data),
    .eos       (in_ch.end_of_string),
    .push      (push)
  );

  // Result queue towards the output channel.
  dss_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .can_take (can_take),
    .out_ch   (out_ch)
  );

`ifndef SYNTHESIS
  // A transaction that closes a string always leaves a result to deliver.
  a_eos_gives_output: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_ch.end_of_string && push.cnt != '0) |=> out_ch.valid)
    else $error("end of string left no result queued");

  // Back-pressure on the input only comes from queued results.
  a_stall_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid)
    else $error("input stalled with an empty result queue");

  // A burst never exceeds the byte, the flushed window and the field end.
  a_burst_bound: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> (push.cnt <= RES_CNT_W'(MAX_RES)))
    else $error("result burst too long");

  // A result carrying a byte never marks the end of a string.
  a_last_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.field_end) |-> !out_ch.last)
    else $error("last set on a byte result");
`endif

endmodule

[hw/rtl/dss_core.sv]
module dss_core import dss_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DELIM_W-1:0]   cfg_wdata,
  input  logic                 acc,
  input  logic [7:0]           data,
  input  logic                 has_data,
  input  logic                 eos,
  output push_t                push
);

  logic [DELIM_W-1:0]   delim_r;
  logic [LEN_W-1:0]     len_r;
  logic [7:0]           win_r [MAX_DELIM];
  logic [CNT_W-1:0]     wcnt_r;

  logic [CNT_W-1:0]     len_eff;
  logic [CNT_W-1:0]     wc_in;
  logic [CNT_W-1:0]     cnt_a;
  logic [CNT_W-1:0]     cnt_b;
  logic [7:0]           win_a [MAX_DELIM];
  logic [7:0]           win_b [MAX_DELIM];
  logic                 full;
  logic                 match;
  logic                 active;
  res_t                 r0;
  logic [RES_CNT_W-1:0] n0;
  logic [RES_CNT_W-1:0] k;

  // Lengths above the window size act as the full window.
  assign len_eff = (len_r > LEN_W'(MAX_DELIM)) ? CNT_W'(MAX_DELIM) : CNT_W'(len_r);
  assign active  = (len_eff != '0);

  // Insert the byte, compare the full window, then drop or clear.
  always_comb begin
    wc_in = (wcnt_r >= len_eff) ? len_eff - CNT_W'(1) : wcnt_r;
    for (int i = 0; i < MAX_DELIM; i++) begin
      win_a[i] = (has_data && wc_in[WIN_IDX_W-1:0] == WIN_IDX_W'(i)) ? data : win_r[i];
    end
    cnt_a = has_data ? wc_in + CNT_W'(1) : wcnt_r;
    full  = has_data && (cnt_a == len_eff);

    match = 1'b1;
    for (int i = 0; i < MAX_DELIM; i++) begin
      if (CNT_W'(i) < len_eff && win_a[i] != delim_r[8*i +: 8]) begin
        match = 1'b0;
      end
    end

    r0.out_byte  = match ? 8'd0 : win_a[0];
    r0.field_end = match;
    r0.last      = 1'b0;

    for (int i = 0; i < MAX_DELIM - 1; i++) begin
      win_b[i] = (full && !match) ? win_a[i+1] : win_a[i];
    end
    win_b[MAX_DELIM-1] = win_a[MAX_DELIM-1];

    if (full) begin
      cnt_b = match ? '0 : len_eff - CNT_W'(1);
    end else begin
      cnt_b = cnt_a;
    end
  end

  // Lay out the burst: the byte's result, the flushed window, the field end.
  always_comb begin
    n0       = RES_CNT_W'(full);
    push.en  = acc && active;
    push.cnt = active ? n0 + (eos ? RES_CNT_W'(cnt_b) + RES_CNT_W'(1) : '0) : '0;
    for (int i = 0; i < MAX_RES; i++) begin
      k = RES_CNT_W'(i) - n0;
      if (i == 0 && full) begin
        push.items[i] = r0;
      end else if (k < RES_CNT_W'(cnt_b)) begin
        push.items[i].out_byte  = win_b[k[WIN_IDX_W-1:0]];
        push.items[i].field_end = 1'b0;
        push.items[i].last      = 1'b0;
      end else begin
        push.items[i].out_byte  = 8'd0;
        push.items[i].field_end = 1'b1;
        push.items[i].last      = 1'b1;
      end
    end
  end

  // Configuration registers and window count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r <= DELIM_RESET;
      len_r   <= LEN_RESET;
      wcnt_r  <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_DELIM_BYTES) begin
        delim_r <= cfg_wdata;
      end else begin
        len_r <= cfg_wdata[LEN_W-1:0];
      end
      wcnt_r <= '0;
    end else if (acc) begin
      if (!active || eos) begin
        wcnt_r <= '0;
      end else begin
        wcnt_r <= cnt_b;
      end
    end
  end

  // Window bytes carry no reset; only entries below the count are read.
  always_ff @(posedge clk) begin
    if (acc && active) begin
      for (int i = 0; i < MAX_DELIM; i++) begin
        win_r[i] <= win_b[i];
      end
    end
  end

endmodule

[hw/rtl/dss_outq.sv]
module dss_outq import dss_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  push_t       push,
  output logic        can_take,
  dss_out_if.source   out_ch
);

  res_t              q_r [QDEPTH];
  res_t              q_nxt [QDEPTH];
  logic [QCNT_W-1:0] qcnt_r;
  logic [QCNT_W-1:0] qcnt_nxt;
  logic [QCNT_W-1:0] base;
  logic              drain;

  // Head of the queue drives the result channel.
  assign out_ch.valid     = (qcnt_r != '0);
  assign out_ch.out_byte  = q_r[0].out_byte;
  assign out_ch.field_end = q_r[0].field_end;
  assign out_ch.last      = q_r[0].last;

  assign drain    = out_ch.valid && out_ch.ready;
  assign base     = qcnt_r - QCNT_W'(drain);
  // Room for a whole burst behind at most one waiting result.
  assign can_take = (base <= QCNT_W'(1));

  // Shift out the taken head, then append the new burst.
  always_comb begin
    for (int i = 0; i < QDEPTH - 1; i++) begin
      q_nxt[i] = drain ? q_r[i+1] : q_r[i];
    end
    q_nxt[QDEPTH-1] = q_r[QDEPTH-1];
    if (push.en) begin
      for (int i = 0; i < MAX_RES; i++) begin
        if (base == '0) begin
          q_nxt[i] = push.items[i];
        end else begin
          q_nxt[i+1] = push.items[i];
        end
      end
    end
    qcnt_nxt = base + (push.en ? QCNT_W'(push.cnt) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qcnt_r <= '0;
    end else begin
      qcnt_r <= qcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

endmodule

[dv/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dss_pkg::*;

  localparam int LONG_HOLD    = 80;
  localparam int DRAIN_CYCLES = 12;
  localparam int END_LIMIT    = 50000;
  localparam int PHASE_ITEMS  = 21;

  // Predicts the field pieces of the splitter and checks the results against them.
  class field_split_sb;
    logic [DELIM_W-1:0] delim_word;
    logic [LEN_W-1:0]   len_word;
    logic [7:0]         window [MAX_DELIM];
    int unsigned        fill;
    res_t               pieces_due [$];
    int                 errors;

    function new();
      delim_word = DELIM_RESET;
      len_word   = LEN_RESET;
      fill       = 0;
      errors     = 0;
    endfunction

    function int unsigned eff_len();
      return (len_word > MAX_DELIM) ? MAX_DELIM : int'(len_word);
    endfunction

    function int pending();
      return pieces_due.size();
    endfunction

    // Any register write drops the bytes still waiting in the window.
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DELIM_W-1:0] val);
      if (idx == CFG_DELIM_BYTES) begin
        delim_word = val;
      end else if (idx == CFG_DELIM_LENGTH) begin
        len_word = val[LEN_W-1:0];
      end
      fill = 0;
    endfunction

    function void push_piece(logic [7:0] b, logic fe, logic lst);
      res_t r;
      r.out_byte  = b;
      r.field_end = fe;
      r.last      = lst;
      pieces_due = {pieces_due, r};
    endfunction

    // Works out the pieces that one accepted input transaction gives.
    function void note_input(logic [7:0] d, logic has, logic eos);
      int unsigned n;
      bit hit;
      n = eff_len();
      if (n == 0) begin
        fill = 0;
        return;
      end
      if (has) begin
        window[fill] = d;
        fill++;
        if (fill == n) begin
          hit = 1'b1;
          for (int j = 0; j < n; j++) begin
            if (window[j] != delim_word[8*j +: 8]) hit = 1'b0;
          end
          if (hit) begin
            push_piece(8'h00, 1'b1, 1'b0);
            fill = 0;
          end else begin
            push_piece(window[0], 1'b0, 1'b0);
            for (int j = 0; j < n - 1; j++) window[j] = window[j+1];
            fill = n - 1;
          end
        end
      end
      // End of string flushes the window and closes the last field.
      if (eos) begin
        for (int j = 0; j < fill; j++) push_piece(window[j], 1'b0, 1'b0);
        push_piece(8'h00, 1'b1, 1'b1);
        fill = 0;
      end
    endfunction

    task report_mismatch(string msg);
      $display("tb: mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(res_t got);
      res_t want;
      if (pieces_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte %02h field_end %0b last %0b",
                                  got.out_byte, got.field_end, got.last));
        return;
      end
      want = pieces_due.pop_front();
      if (got.out_byte !== want.out_byte)
        report_mismatch($sformatf("out_byte %02h, expected %02h", got.out_byte, want.out_byte));
      if (got.field_end !== want.field_end)
        report_mismatch($sformatf("field_end %0b, expected %0b", got.field_end, want.field_end));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %0b, expected %0b", got.last, want.last));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DELIM_W-1:0]   cfg_wdata;

  dss_in_if  in_ch ();
  dss_out_if out_ch ();

  delimiter_string_split dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  field_split_sb sb;
  bit            tx_idle_on;
  bit            rx_idle_on;
  bit            long_hold_req;
  int unsigned   rx_hold_left;
  int unsigned   counted_items;

  // Clock, period 8 ns.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 45);
  endfunction

  // A byte that is often one of the delimiter bytes, so partial matches are frequent.
  function automatic logic [7:0] pick_byte();
    int unsigned n;
    int unsigned j;
    n = sb.eff_len();
    if (n > 0 && $urandom_range(0, 1) == 1) begin
      j = $urandom_range(0, n - 1);
      return sb.delim_word[8*j +: 8];
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // Offers one input transaction and waits until it is taken.
  task automatic send_item(input logic [7:0] d, input logic has, input logic eos);
    int unsigned gap;
    gap = tx_idle_on ? pick_gap() : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.data          <= d;
    in_ch.has_data      <= has;
    in_ch.end_of_string <= eos;
    do @(posedge clk); while (!in_ch.ready);
    if (sb.eff_len() != 0 && (has || eos)) counted_items++;
  endtask

  // Stops offering and waits until every expected result has come.
  task automatic wait_drained(input int settle);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DELIM_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // One string built from delimiters, delimiter prefixes and loose bytes.
  task automatic send_string();
    int unsigned n;
    int unsigned chunks;
    int unsigned kind;
    int unsigned k;
    n      = sb.eff_len();
    chunks = $urandom_range(0, 5);
    for (int c = 0; c < chunks; c++) begin
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
        for (int j = 0; j < n; j++) send_item(sb.delim_word[8*j +: 8], 1'b1, 1'b0);
      end else if (kind < 5 && n > 1) begin
        k = $urandom_range(1, n - 1);
        for (int j = 0; j < k; j++) send_item(sb.delim_word[8*j +: 8], 1'b1, 1'b0);
      end else begin
        k = $urandom_range(1, 3);
        for (int j = 0; j < k; j++) send_item(pick_byte(), 1'b1, 1'b0);
      end
    end
    if ($urandom_range(0, 1) == 1) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    else send_item(pick_byte(), 1'b1, 1'b1);
  endtask

  // Noise: every field random, including ignored transactions with neither flag.
  task automatic send_noise();
    send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  task automatic run_phase(input int unsigned budget, input bit pause_midway);
    int unsigned goal;
    int unsigned half;
    bit paused;
    goal   = counted_items + budget;
    half   = counted_items + budget / 2;
    paused = 1'b0;
    while (counted_items < goal) begin
      if ($urandom_range(0, 99) < 15) send_noise();
      else send_string();
      if (pause_midway && !paused && counted_items >= half) begin
        wait_drained(0);
        paused = 1'b1;
      end
    end
  endtask

  // Input and output monitors.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_input(in_ch.data, in_ch.has_data, in_ch.end_of_string);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      res_t got;
      got.out_byte  = out_ch.out_byte;
      got.field_end = out_ch.field_end;
      got.last      = out_ch.last;
      sb.check_result(got);
    end
  end

  // Result receiver: random stalls, and one long hold-off on request.
  initial begin
    out_ch.ready = 1'b0;
    rx_hold_left = 0;
    forever begin
      @(posedge clk);
      if (rx_hold_left > 0) begin
        out_ch.ready <= 1'b0;
        rx_hold_left--;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        rx_hold_left = LONG_HOLD - 1;
      end else if (!rx_idle_on) begin
        out_ch.ready <= 1'b1;
      end else begin
        rx_hold_left = pick_gap();
        if (rx_hold_left == 0) begin
          out_ch.ready <= 1'b1;
        end else begin
          out_ch.ready <= 1'b0;
          rx_hold_left--;
        end
      end
    end
  end

  // Overall time limit.
  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

  // Main sequence.
  initial begin
    logic [DELIM_W-1:0] word;
    logic [DELIM_W-1:0] lw;
    int unsigned        n;

    sb                  = new();
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = CFG_DELIM_BYTES;
    cfg_wdata           = '0;
    in_ch.valid         = 1'b0;
    in_ch.data          = 8'h00;
    in_ch.has_data      = 1'b0;
    in_ch.end_of_string = 1'b0;
    tx_idle_on          = 1'b1;
    rx_idle_on          = 1'b1;
    long_hold_req       = 1'b0;
    counted_items       = 0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset delimiter: empty string, a split, and a byte that also ends the string.
    send_item(8'h00, 1'b0, 1'b1);
    send_item("a", 1'b1, 1'b0);
    send_item(",", 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1);
    wait_drained(DRAIN_CYCLES);

    // Repeated-byte delimiter: leftmost match without overlap.
    cfg_write(CFG_DELIM_BYTES, 64'h6161);
    cfg_write(CFG_DELIM_LENGTH, 64'd2);
    send_item("a", 1'b1, 1'b0);
    send_item("a", 1'b1, 1'b0);
    send_item("a", 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    wait_drained(DRAIN_CYCLES);

    // Zero length: everything is ignored.
    cfg_write(CFG_DELIM_LENGTH, 64'd0);
    send_item("x", 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    wait_drained(DRAIN_CYCLES);

    // Oversized length acts as eight; a near match closed by end of string gives
    // the longest burst.
    cfg_write(CFG_DELIM_BYTES, 64'h0807_0605_0403_0201);
    cfg_write(CFG_DELIM_LENGTH, 64'hFFFF_FFFF_FFFF_FFFD);
    for (int j = 1; j <= 7; j++) send_item(8'(j), 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
    wait_drained(DRAIN_CYCLES);

    // Random phases, each under its own register setting.
    for (int p = 0; p < 10; p++) begin
      word = {$urandom(), $urandom()};
      lw   = {$urandom(), $urandom()};
      case (p)
        0: n = 1;
        1: begin
          word = {8{8'($urandom_range(0, 255))}};
          n    = $urandom_range(2, 3);
        end
        2: begin
          word = '1;
          n    = 8;
        end
        3: begin
          word = '0;
          n    = 8;
        end
        5: n = 0;
        6: n = $urandom_range(9, 15);
        7: n = 4;
        9: n = 8;
        default: n = $urandom_range(1, 8);
      endcase
      lw[LEN_W-1:0] = LEN_W'(n);
      if (p == 5) begin
        cfg_write(CFG_DELIM_LENGTH, lw);
      end else if (p == 6) begin
        cfg_write(CFG_DELIM_LENGTH, lw);
        cfg_write(CFG_DELIM_BYTES, word);
      end else begin
        cfg_write(CFG_DELIM_BYTES, word);
        cfg_write(CFG_DELIM_LENGTH, lw);
      end

      tx_idle_on = (p != 9) && (p != 7);
      rx_idle_on = (p != 9);
      if (p == 7) long_hold_req = 1'b1;

      if (p == 5) begin
        for (int i = 0; i < 10; i++) send_noise();
      end else begin
        run_phase(PHASE_ITEMS + ((p == 7) ? 10 : 0), p == 8);
      end
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      wait_drained(DRAIN_CYCLES);
    end

    // Final drain, bounded.
    in_ch.valid <= 1'b0;
    @(posedge clk);
    for (int w = 0; w < END_LIMIT && sb.pending() != 0; w++) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d expected results never arrived", sb.pending()));

    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[delimiter_string_split.f]
hw/rtl/dss_pkg.sv
hw/rtl/dss_chan_if.sv
hw/rtl/dss_core.sv
hw/rtl/dss_outq.sv
hw/rtl/delimiter_string_split.sv
dv/testbench.sv
